@@ design/bpsd_pkg.sv @@
// shared types and constants for the button press sequence decoder
// no dependencies
package bpsd_pkg;

    localparam int unsigned DEB_W   = 8;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [DEB_W-1:0] DEB_MAX = '1;

    localparam logic [DEB_W-1:0] RST_DEBOUNCE_POLLS = 8'd20;
    localparam logic [MS_W-1:0]  RST_LONG_PRESS_MS  = 16'd500;
    localparam logic [MS_W-1:0]  RST_IDLE_CLEAR_MS  = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_POLLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_CLEAR_MS  = 2'd2;

    typedef enum logic [1:0] {
        CODE_FREE  = 2'd0,
        CODE_SHORT = 2'd1,
        CODE_LONG  = 2'd2
    } t_code;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_UP   = 2'd1,
        CMD_DOWN = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [DEB_W-1:0] debounce_polls;
        logic [MS_W-1:0]  long_press_ms;
        logic [MS_W-1:0]  idle_clear_ms;
    } t_cfg;

endpackage

@@ design/bpsd_in_if.sv @@
// poll item channel: key level and millisecond timestamp
// depends on bpsd_pkg
interface bpsd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          key_level;
    logic [bpsd_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, key_level, now_ms, input ready);
    modport sink   (input valid, key_level, now_ms, output ready);
endinterface

@@ design/bpsd_out_if.sv @@
// result item channel: command and led level
// no dependencies
interface bpsd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic       led_on;

    modport source (output valid, command, led_on, input ready);
    modport sink   (input valid, command, led_on, output ready);
endinterface

@@ design/bpsd_cfg_if.sv @@
// configuration write channel: register index and write data
// depends on bpsd_pkg
interface bpsd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bpsd_pkg::CFG_IDX_W-1:0] index;
    logic [bpsd_pkg::MS_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/button_press_sequence_decoder_unit.sv @@
// top level of the button press sequence decoder: input register, core, result register
// depends on bpsd_pkg, the channel interfaces, bpsd_cfg and bpsd_core
//
// One poll item goes in and one result item comes out. A poll is held in the
// input register, the debounce, hold timing and press-list update run in
// combinational logic in the core, and the result is registered on the output
// when the input register holds a poll and the output register is empty or
// being taken. One poll per cycle is sustained as long as the output side takes
// results. No clearing pass is needed after reset; configuration is written
// through the separate write channel, and the user must write it only while no
// poll is in flight, as the block itself does not enforce this.
module button_press_sequence_decoder_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bpsd_in_if.sink      i_in,
    bpsd_out_if.source   o_out,
    bpsd_cfg_if.sink     i_cfg
);

    logic                          r_in_valid;
    logic                          r_key;
    logic [bpsd_pkg::TIME_W-1:0]   r_now;
    logic                          r_out_valid;
    logic [1:0]                    r_cmd;
    logic                          r_led;

    logic                          w_adv;
    bpsd_pkg::t_cfg                w_cfg;
    bpsd_pkg::t_cmd                w_cmd;
    logic                          w_led;

    bpsd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    bpsd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_adv),
        .i_key_level (r_key),
        .i_now_ms    (r_now),
        .i_cfg       (w_cfg),
        .o_command   (w_cmd),
        .o_led_on    (w_led)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_key <= i_in.key_level;
            r_now <= i_in.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cmd <= w_cmd;
            r_led <= w_led;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.command = r_cmd;
    assign o_out.led_on  = r_led;

    a_down_sets_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.command == bpsd_pkg::CMD_DOWN |-> o_out.led_on)
        else $error("down item without led set");

    a_up_clears_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.command == bpsd_pkg::CMD_UP |-> !o_out.led_on)
        else $error("up item with led still set");

    a_held_poll_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_now) && $stable(r_key))
        else $error("stalled poll item lost or changed");

    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("processed poll gave no result item");

endmodule

@@ design/bpsd_cfg.sv @@
// configuration register file for the decoder
// depends on bpsd_pkg and bpsd_cfg_if
module bpsd_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bpsd_cfg_if.sink          i_cfg,
    output bpsd_pkg::t_cfg    o_cfg
);

    bpsd_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_polls <= bpsd_pkg::RST_DEBOUNCE_POLLS;
            r_cfg.long_press_ms  <= bpsd_pkg::RST_LONG_PRESS_MS;
            r_cfg.idle_clear_ms  <= bpsd_pkg::RST_IDLE_CLEAR_MS;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bpsd_pkg::CFG_DEBOUNCE_POLLS: begin
                    r_cfg.debounce_polls <= i_cfg.data[bpsd_pkg::DEB_W-1:0];
                end
                bpsd_pkg::CFG_LONG_PRESS_MS: begin
                    r_cfg.long_press_ms <= i_cfg.data;
                end
                bpsd_pkg::CFG_IDLE_CLEAR_MS: begin
                    r_cfg.idle_clear_ms <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ design/bpsd_core.sv @@
// per-poll state update: debounce, hold timing, press list and decode
// depends on bpsd_pkg
module bpsd_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic                           i_key_level,
    input  logic [bpsd_pkg::TIME_W-1:0]    i_now_ms,
    input  bpsd_pkg::t_cfg                 i_cfg,
    output bpsd_pkg::t_cmd                 o_command,
    output logic                           o_led_on
);

    logic [bpsd_pkg::TIME_W-1:0] r_press_start, n_press_start;
    logic [bpsd_pkg::TIME_W-1:0] r_release, n_release;
    logic [bpsd_pkg::TIME_W-1:0] r_idle, n_idle;
    logic [bpsd_pkg::DEB_W-1:0]  r_dcount, n_dcount;
    logic                        r_pressed, n_pressed;
    logic                        r_slot, n_slot;
    bpsd_pkg::t_code             r_codes [2];
    bpsd_pkg::t_code             n_codes [2];
    logic                        r_led, n_led;

    logic [bpsd_pkg::TIME_W-1:0] w_hold;
    logic                        w_counted;
    logic                        w_release;
    logic                        w_clear;
    bpsd_pkg::t_code             w_class;
    bpsd_pkg::t_cmd              w_cmd;

    always_comb begin
        w_hold = i_now_ms - r_press_start;
        if (w_hold == '0) begin
            w_class = bpsd_pkg::CODE_FREE;
        end else if (w_hold < {{(bpsd_pkg::TIME_W-bpsd_pkg::MS_W){1'b0}},
                               i_cfg.long_press_ms}) begin
            w_class = bpsd_pkg::CODE_SHORT;
        end else begin
            w_class = bpsd_pkg::CODE_LONG;
        end
    end

    always_comb begin
        n_press_start = r_press_start;
        n_release     = r_release;
        n_idle        = r_idle;
        n_pressed     = r_pressed;
        n_slot        = r_slot;
        n_codes       = r_codes;
        n_led         = r_led;
        w_cmd         = bpsd_pkg::CMD_NONE;

        if (!i_key_level) begin
            n_dcount      = '0;
            n_press_start = i_now_ms;
            n_idle        = i_now_ms - r_release;
        end else if (r_dcount == bpsd_pkg::DEB_MAX) begin
            n_dcount = r_dcount;
        end else begin
            n_dcount = r_dcount + 1'b1;
        end

        w_counted = i_key_level && (n_dcount > i_cfg.debounce_polls);
        w_release = !i_key_level && r_pressed;

        if (w_counted) begin
            n_idle          = '0;
            n_codes[r_slot] = w_class;
            n_pressed       = 1'b1;
        end else if (w_release) begin
            n_release        = i_now_ms;
            n_pressed        = 1'b0;
            n_idle           = '0;
            n_slot           = ~r_slot;
            n_codes[~r_slot] = bpsd_pkg::CODE_FREE;
        end

        w_clear = n_idle >= {{(bpsd_pkg::TIME_W-bpsd_pkg::MS_W){1'b0}},
                             i_cfg.idle_clear_ms};
        if (w_clear) begin
            n_codes[0] = bpsd_pkg::CODE_FREE;
            n_codes[1] = bpsd_pkg::CODE_FREE;
            n_slot     = 1'b0;
        end

        if (n_codes[0] == bpsd_pkg::CODE_LONG && n_codes[1] == bpsd_pkg::CODE_FREE) begin
            n_led = 1'b1;
            w_cmd = bpsd_pkg::CMD_DOWN;
        end else if (n_codes[0] == bpsd_pkg::CODE_SHORT
                     && n_codes[1] == bpsd_pkg::CODE_LONG) begin
            n_led = 1'b0;
            w_cmd = bpsd_pkg::CMD_UP;
        end

        if (w_cmd != bpsd_pkg::CMD_NONE && !i_key_level) begin
            n_codes[0] = bpsd_pkg::CODE_FREE;
            n_codes[1] = bpsd_pkg::CODE_FREE;
            n_slot     = 1'b0;
        end
    end

    assign o_command = w_cmd;
    assign o_led_on  = n_led;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_start <= '0;
            r_release     <= '0;
            r_idle        <= '0;
            r_dcount      <= '0;
            r_pressed     <= 1'b0;
            r_slot        <= 1'b0;
            r_codes[0]    <= bpsd_pkg::CODE_FREE;
            r_codes[1]    <= bpsd_pkg::CODE_FREE;
            r_led         <= 1'b0;
        end else if (i_step) begin
            r_press_start <= n_press_start;
            r_release     <= n_release;
            r_idle        <= n_idle;
            r_dcount      <= n_dcount;
            r_pressed     <= n_pressed;
            r_slot        <= n_slot;
            r_codes       <= n_codes;
            r_led         <= n_led;
        end
    end

endmodule
